// ===== hdl/http_request_header_parser_defines.svh =====
// Assertion macros shared by the request header parser modules.
// No dependencies; included by the files that carry assertions.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define HRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define HRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hrp_pkg.sv =====
// Shared types, constants and literal tables for the request header parser.
// No dependencies.
`default_nettype none

package hrp_pkg;

    localparam int HRP_QUEUE_DEPTH = 4;

    // Event codes on the result channel
    localparam logic [1:0] EV_URL_BYTE = 2'd0;
    localparam logic [1:0] EV_URL_END  = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;
    localparam logic [1:0] EV_BAD      = 2'd3;

    // Byte of the stream with its class flags, as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       is_sp;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
    } t_byte_cls;

    // "GET " <url> "HTTP/1." ; the url slot holds 0
    function automatic logic [7:0] hrp_req_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h47;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h20;
            4'd5:    c = 8'h48;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h54;
            4'd8:    c = 8'h50;
            4'd9:    c = 8'h2F;
            4'd10:   c = 8'h31;
            4'd11:   c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "connection"
    function automatic logic [7:0] hrp_key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h63;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h6F;
            4'd9:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "keep-alive"
    function automatic logic [7:0] hrp_ka_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6B;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h70;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h76;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "close"
    function automatic logic [7:0] hrp_cl_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6C;
            4'd2:    c = 8'h6F;
            4'd3:    c = 8'h73;
            4'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hrp_front.sv =====
// Front end: takes request bytes and tags them with their character class.
// Depends on hrp_pkg.
`default_nettype none

module hrp_front
    import hrp_pkg::*;
(
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_byte_cls       o_cls
);

    logic w_upper;

    assign w_upper    = (i_stream_byte >= 8'h41) && (i_stream_byte <= 8'h5A);
    assign o_in_ready = i_rst_n && !i_queue_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_cls.data     = i_stream_byte;
        o_cls.lower    = w_upper ? (i_stream_byte + 8'h20) : i_stream_byte;
        o_cls.is_sp    = (i_stream_byte == 8'h20);
        o_cls.is_cr    = (i_stream_byte == 8'h0D);
        o_cls.is_lf    = (i_stream_byte == 8'h0A);
        o_cls.is_colon = (i_stream_byte == 8'h3A);
    end

endmodule

`default_nettype wire

// ===== hdl/hrp_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
// Depends on hrp_pkg and the assertion macro header.
`default_nettype none

`include "http_request_header_parser_defines.svh"

module hrp_queue
    import hrp_pkg::*;
#(
    parameter int DEPTH = HRP_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_byte_cls       i_cls,
    input  wire logic       i_pop,
    output logic            o_valid,
    output logic            o_full,
    output t_byte_cls       o_cls
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_byte_cls        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_cls   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : (r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : (r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    `HRP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "queue overfilled")
    `HRP_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `HRP_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule

`default_nettype wire

// ===== hdl/hrp_back.sv =====
// Parser back end: request line and header state machine with output register.
// Depends on hrp_pkg and the assertion macro header.
`default_nettype none

`include "http_request_header_parser_defines.svh"

module hrp_back
    import hrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cls_valid,
    input  t_byte_cls       i_cls,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_event_kind,
    output logic [7:0]      o_url_byte,
    output logic            o_version_is_11,
    output logic            o_keep_alive
);

    // States 0..11 walk the request line literal; 4 is the url itself
    localparam logic [4:0] ST_REQ_G    = 5'd0;
    localparam logic [4:0] ST_REQ_SP   = 5'd3;
    localparam logic [4:0] ST_URL      = 5'd4;
    localparam logic [4:0] ST_REQ_H    = 5'd5;
    localparam logic [4:0] ST_MINOR    = 5'd12;
    localparam logic [4:0] ST_REQ_CR   = 5'd13;
    localparam logic [4:0] ST_REQ_LF   = 5'd14;
    localparam logic [4:0] ST_LINE     = 5'd15;
    localparam logic [4:0] ST_KEY      = 5'd16;
    localparam logic [4:0] ST_SP_PLAIN = 5'd17;
    localparam logic [4:0] ST_SP_CONN  = 5'd18;
    localparam logic [4:0] ST_VALUE    = 5'd19;
    localparam logic [4:0] ST_CVALUE   = 5'd20;
    localparam logic [4:0] ST_VALUE_LF = 5'd21;
    localparam logic [4:0] ST_FINAL_LF = 5'd22;

    localparam logic [3:0] LONG_LEN  = 4'd10;
    localparam logic [3:0] CLOSE_LEN = 4'd5;

    logic [4:0] r_state,   n_state;
    logic       r_saw_get, n_saw_get;
    logic       r_v11,     n_v11;
    logic       r_saw_ka,  n_saw_ka;
    logic       r_saw_cl,  n_saw_cl;
    logic [3:0] r_key_idx, n_key_idx;
    logic       r_key_mis, n_key_mis;
    logic [3:0] r_val_idx, n_val_idx;
    logic       r_ka_mis,  n_ka_mis;
    logic       r_cl_mis,  n_cl_mis;

    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_url;
    logic       r_ev_v11;
    logic       r_ev_ka;

    logic       w_emit;
    logic [1:0] w_kind;
    logic [7:0] w_url;
    logic       w_ev_v11;
    logic       w_ev_ka;
    logic       w_bad;
    logic       w_done;
    logic [3:0] w_kidx;
    logic       w_kmis;

    // Advance whenever the output register is free or being emptied
    assign o_pop = i_cls_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_saw_get = r_saw_get;
        n_v11     = r_v11;
        n_saw_ka  = r_saw_ka;
        n_saw_cl  = r_saw_cl;
        n_key_idx = r_key_idx;
        n_key_mis = r_key_mis;
        n_val_idx = r_val_idx;
        n_ka_mis  = r_ka_mis;
        n_cl_mis  = r_cl_mis;
        w_emit    = 1'b0;
        w_kind    = EV_URL_BYTE;
        w_url     = 8'h00;
        w_ev_v11  = 1'b0;
        w_ev_ka   = 1'b0;
        w_bad     = 1'b0;
        w_done    = 1'b0;
        w_kidx    = r_key_idx;
        w_kmis    = r_key_mis;

        if (o_pop) begin
            if ((r_state < ST_MINOR) && (r_state != ST_URL)) begin
                if (i_cls.data != hrp_req_char(r_state[3:0])) begin
                    w_bad = 1'b1;
                end else begin
                    if (r_state == ST_REQ_SP) begin
                        n_saw_get = 1'b1;
                    end
                    n_state = r_state + 5'd1;
                end
            end else begin
                case (r_state)
                    ST_URL: begin
                        w_emit = 1'b1;
                        if (i_cls.is_sp) begin
                            n_state = ST_REQ_H;
                            w_kind  = EV_URL_END;
                        end else begin
                            w_url = i_cls.data;
                        end
                    end
                    ST_MINOR: begin
                        if ((i_cls.data == 8'h30) || (i_cls.data == 8'h31)) begin
                            n_v11   = (i_cls.data == 8'h31);
                            n_state = ST_REQ_CR;
                        end else begin
                            w_bad = 1'b1;
                        end
                    end
                    ST_REQ_CR: begin
                        if (i_cls.is_cr) n_state = ST_REQ_LF;
                        else             w_bad   = 1'b1;
                    end
                    ST_REQ_LF, ST_VALUE_LF: begin
                        if (i_cls.is_lf) n_state = ST_LINE;
                        else             w_bad   = 1'b1;
                    end
                    ST_LINE, ST_KEY: begin
                        if ((r_state == ST_LINE) && i_cls.is_cr) begin
                            n_state = ST_FINAL_LF;
                        end else begin
                            // a new line restarts the key compare
                            if (r_state == ST_LINE) begin
                                w_kidx = 4'd0;
                                w_kmis = 1'b0;
                            end
                            n_key_idx = w_kidx;
                            n_key_mis = w_kmis;
                            if (i_cls.is_cr || i_cls.is_lf) begin
                                w_bad = 1'b1;
                            end else if (i_cls.is_colon) begin
                                n_state   = (!w_kmis && (w_kidx == LONG_LEN)) ?
                                            ST_SP_CONN : ST_SP_PLAIN;
                                n_key_idx = 4'd0;
                                n_key_mis = 1'b0;
                            end else begin
                                if (w_kidx >= LONG_LEN) begin
                                    n_key_mis = 1'b1;
                                end else begin
                                    n_key_mis = w_kmis ||
                                                (i_cls.lower != hrp_key_char(w_kidx));
                                    n_key_idx = w_kidx + 4'd1;
                                end
                                n_state = ST_KEY;
                            end
                        end
                    end
                    ST_SP_PLAIN, ST_SP_CONN: begin
                        if (i_cls.is_sp) begin
                            n_val_idx = 4'd0;
                            n_ka_mis  = 1'b0;
                            n_cl_mis  = 1'b0;
                            n_state   = (r_state == ST_SP_CONN) ? ST_CVALUE : ST_VALUE;
                        end else begin
                            w_bad = 1'b1;
                        end
                    end
                    ST_VALUE: begin
                        if (i_cls.is_cr) n_state = ST_VALUE_LF;
                    end
                    ST_CVALUE: begin
                        if (i_cls.is_cr) begin
                            if (!r_ka_mis && (r_val_idx == LONG_LEN))  n_saw_ka = 1'b1;
                            if (!r_cl_mis && (r_val_idx == CLOSE_LEN)) n_saw_cl = 1'b1;
                            n_state = ST_VALUE_LF;
                        end else if (r_val_idx >= LONG_LEN) begin
                            n_ka_mis = 1'b1;
                            n_cl_mis = 1'b1;
                        end else begin
                            n_ka_mis  = r_ka_mis ||
                                        (i_cls.data != hrp_ka_char(r_val_idx));
                            n_cl_mis  = r_cl_mis || (r_val_idx >= CLOSE_LEN) ||
                                        (i_cls.data != hrp_cl_char(r_val_idx));
                            n_val_idx = r_val_idx + 4'd1;
                        end
                    end
                    ST_FINAL_LF: begin
                        if (i_cls.is_lf) w_done = 1'b1;
                        else             w_bad  = 1'b1;
                    end
                    default: begin
                        w_bad = 1'b1;
                    end
                endcase
            end

            if (w_bad || w_done) begin
                w_emit = 1'b1;
                if (w_bad) begin
                    w_kind   = EV_BAD;
                    w_ev_v11 = r_saw_get ? r_v11 : 1'b1;
                end else begin
                    w_kind   = EV_COMPLETE;
                    w_ev_v11 = r_v11;
                    w_ev_ka  = !r_saw_cl && (r_saw_ka || r_v11);
                end
                // drop all request state for the next request
                n_state   = ST_REQ_G;
                n_saw_get = 1'b0;
                n_v11     = 1'b0;
                n_saw_ka  = 1'b0;
                n_saw_cl  = 1'b0;
                n_key_idx = 4'd0;
                n_key_mis = 1'b0;
                n_val_idx = 4'd0;
                n_ka_mis  = 1'b0;
                n_cl_mis  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_REQ_G;
            r_saw_get   <= 1'b0;
            r_v11       <= 1'b0;
            r_saw_ka    <= 1'b0;
            r_saw_cl    <= 1'b0;
            r_key_idx   <= 4'd0;
            r_key_mis   <= 1'b0;
            r_val_idx   <= 4'd0;
            r_ka_mis    <= 1'b0;
            r_cl_mis    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_saw_get <= n_saw_get;
            r_v11     <= n_v11;
            r_saw_ka  <= n_saw_ka;
            r_saw_cl  <= n_saw_cl;
            r_key_idx <= n_key_idx;
            r_key_mis <= n_key_mis;
            r_val_idx <= n_val_idx;
            r_ka_mis  <= n_ka_mis;
            r_cl_mis  <= n_cl_mis;
            if (o_pop) begin
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind   <= w_kind;
            r_url    <= w_url;
            r_ev_v11 <= w_ev_v11;
            r_ev_ka  <= w_ev_ka;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_kind;
    assign o_url_byte      = r_url;
    assign o_version_is_11 = r_ev_v11;
    assign o_keep_alive    = r_ev_ka;

    `HRP_ASSERT_IMP(a_url_in_url, i_clk, i_rst_n, o_pop && w_emit && (w_kind == EV_URL_BYTE), r_state == ST_URL, "url byte outside url")
    `HRP_ASSERT_NXT(a_restart, i_clk, i_rst_n, o_pop && (w_bad || w_done), (r_state == ST_REQ_G) && !r_saw_get, "parser did not restart")
    `HRP_ASSERT_IMP(a_idx_bound, i_clk, i_rst_n, 1'b1, (r_key_idx <= LONG_LEN) && (r_val_idx <= LONG_LEN), "match index past bound")

endmodule

`default_nettype wire

// ===== hdl/http_request_header_parser.sv =====
// HTTP/1.x request header parser, one byte per transfer on the input channel.
// Input: i_in_valid / o_in_ready with i_stream_byte. Output: o_out_valid /
// i_out_ready with o_event_kind, o_url_byte, o_version_is_11, o_keep_alive.
// Each accepted byte gives zero or one event: a url byte, url end, request
// complete (version and keep-alive decision) or bad request (reply version).
// The front end tags each byte and writes it into a queue of DEPTH entries;
// the back end state machine takes one byte per cycle from the queue into a
// single output register, while that register is free or being emptied.
// An accepted byte is first written into the queue; its event is then
// registered in the output register. Throughput: one byte per cycle while the
// output register is free or being emptied, set by the state machine's pops.
// When the receiver stalls, the output register holds its event and the queue
// absorbs up to DEPTH further bytes before o_in_ready falls.
// Reset (i_rst_n low, synchronous) empties the queue and the output register
// and puts the parser at the start of a request line. After a complete or bad
// request event the parser restarts on its own.
// Depends on hrp_pkg, hrp_front, hrp_queue and hrp_back.
`default_nettype none

module http_request_header_parser
    import hrp_pkg::*;
#(
    parameter int DEPTH = HRP_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_stream_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_event_kind,
    output logic [7:0]      o_url_byte,
    output logic            o_version_is_11,
    output logic            o_keep_alive
);

    t_byte_cls w_front_cls;
    t_byte_cls w_queue_cls;
    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_queue_valid;

    hrp_front u_front (
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_cls         (w_front_cls)
    );

    hrp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_front_cls),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_full  (w_full),
        .o_cls   (w_queue_cls)
    );

    hrp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cls_valid     (w_queue_valid),
        .i_cls           (w_queue_cls),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_kind    (o_event_kind),
        .o_url_byte      (o_url_byte),
        .o_version_is_11 (o_version_is_11),
        .o_keep_alive    (o_keep_alive)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for http_request_header_parser: random and directed byte
// streams, a behavioural parser that predicts every event, and ready/valid idling.
// Depends on hrp_pkg for the event codes.

module tb_top;
    import hrp_pkg::*;

    localparam int FEED_TARGET  = 1750;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] SPACE = 8'h20;
    localparam logic [7:0] COLON = 8'h3A;

    // The url slot of the request line text is never compared
    localparam logic [8*12-1:0] REQ_TEXT = "GET ?HTTP/1.";
    localparam logic [8*10-1:0] KEY_TEXT = "connection";
    localparam logic [8*10-1:0] KA_TEXT  = "keep-alive";
    localparam logic [8*5-1:0]  CL_TEXT  = "close";

    // Parser positions; 0 to 11 walk the request line text
    localparam logic [4:0] PS_START    = 5'd0;
    localparam logic [4:0] PS_GET_SP   = 5'd3;
    localparam logic [4:0] PS_URL      = 5'd4;
    localparam logic [4:0] PS_HTTP     = 5'd5;
    localparam logic [4:0] PS_MINOR    = 5'd12;
    localparam logic [4:0] PS_REQ_CR   = 5'd13;
    localparam logic [4:0] PS_REQ_LF   = 5'd14;
    localparam logic [4:0] PS_LINE     = 5'd15;
    localparam logic [4:0] PS_KEY      = 5'd16;
    localparam logic [4:0] PS_SP_PLAIN = 5'd17;
    localparam logic [4:0] PS_SP_CONN  = 5'd18;
    localparam logic [4:0] PS_VALUE    = 5'd19;
    localparam logic [4:0] PS_CVALUE   = 5'd20;
    localparam logic [4:0] PS_VALUE_LF = 5'd21;
    localparam logic [4:0] PS_FINAL_LF = 5'd22;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] url;
        logic       v11;
        logic       ka;
    } t_parse_event;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_stream_byte = 8'h00;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_event_kind;
    logic [7:0] o_url_byte;
    logic       o_version_is_11;
    logic       o_keep_alive;

    logic [7:0]   byte_feed[$];
    logic [7:0]   request_text[$];
    t_parse_event due_events[$];

    int   feed_total  = 0;
    int   bytes_taken = 0;
    int   errors      = 0;
    int   cycle_count = 0;
    logic in_taken    = 1'b0;
    int   in_gap      = 0;
    int   out_gap     = 0;
    int   hold_left   = 0;
    logic hold_used   = 1'b0;

    // Predicted parser state
    logic [4:0] p_state;
    logic       got_url;
    logic       ver11;
    logic       saw_ka;
    logic       saw_cl;
    logic [3:0] key_idx;
    logic       key_bad;
    logic [3:0] val_idx;
    logic       ka_bad;
    logic       cl_bad;

    http_request_header_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_stream_byte  (i_stream_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_url_byte     (o_url_byte),
        .o_version_is_11(o_version_is_11),
        .o_keep_alive   (o_keep_alive)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic restart_parse();
        p_state = PS_START;
        got_url = 1'b0;
        ver11   = 1'b0;
        saw_ka  = 1'b0;
        saw_cl  = 1'b0;
        key_idx = 4'd0;
        key_bad = 1'b0;
        val_idx = 4'd0;
        ka_bad  = 1'b0;
        cl_bad  = 1'b0;
    endtask

    task automatic post_event(input logic [1:0] kind, input logic [7:0] url,
                              input logic v11, input logic ka);
        t_parse_event ev;
        ev.kind = kind;
        ev.url  = url;
        ev.v11  = v11;
        ev.ka   = ka;
        due_events.push_back(ev);
    endtask

    // Reply version is 1.1 until the url has started
    task automatic reject_request();
        logic v11;
        v11 = got_url ? ver11 : 1'b1;
        restart_parse();
        post_event(EV_BAD, 8'h00, v11, 1'b0);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] lc;
        logic       v11;
        logic       ka;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (p_state < PS_MINOR && p_state != PS_URL) begin
            if (b != REQ_TEXT[8*(11 - p_state) +: 8]) begin
                reject_request();
            end else begin
                if (p_state == PS_GET_SP)
                    got_url = 1'b1;
                p_state = p_state + 5'd1;
            end
        end else begin
            case (p_state)
                PS_URL: begin
                    if (b == SPACE) begin
                        p_state = PS_HTTP;
                        post_event(EV_URL_END, 8'h00, 1'b0, 1'b0);
                    end else begin
                        post_event(EV_URL_BYTE, b, 1'b0, 1'b0);
                    end
                end
                PS_MINOR: begin
                    if (b != "0" && b != "1") begin
                        reject_request();
                    end else begin
                        ver11   = (b == "1");
                        p_state = PS_REQ_CR;
                    end
                end
                PS_REQ_CR: begin
                    if (b != CR)
                        reject_request();
                    else
                        p_state = PS_REQ_LF;
                end
                PS_REQ_LF, PS_VALUE_LF: begin
                    if (b != LF)
                        reject_request();
                    else
                        p_state = PS_LINE;
                end
                PS_LINE, PS_KEY: begin
                    if (p_state == PS_LINE && b == CR) begin
                        p_state = PS_FINAL_LF;
                    end else begin
                        if (p_state == PS_LINE) begin
                            key_idx = 4'd0;
                            key_bad = 1'b0;
                        end
                        if (b == CR || b == LF) begin
                            reject_request();
                        end else if (b == COLON) begin
                            p_state = (!key_bad && key_idx == 4'd10) ? PS_SP_CONN : PS_SP_PLAIN;
                            key_idx = 4'd0;
                            key_bad = 1'b0;
                        end else begin
                            // counter sticks at its bound once the key is too long
                            if (key_idx >= 4'd10) begin
                                key_bad = 1'b1;
                            end else begin
                                if (lc != KEY_TEXT[8*(9 - key_idx) +: 8])
                                    key_bad = 1'b1;
                                key_idx = key_idx + 4'd1;
                            end
                            p_state = PS_KEY;
                        end
                    end
                end
                PS_SP_PLAIN, PS_SP_CONN: begin
                    if (b != SPACE) begin
                        reject_request();
                    end else begin
                        val_idx = 4'd0;
                        ka_bad  = 1'b0;
                        cl_bad  = 1'b0;
                        p_state = (p_state == PS_SP_CONN) ? PS_CVALUE : PS_VALUE;
                    end
                end
                PS_VALUE: begin
                    if (b == CR)
                        p_state = PS_VALUE_LF;
                end
                PS_CVALUE: begin
                    if (b == CR) begin
                        if (!ka_bad && val_idx == 4'd10)
                            saw_ka = 1'b1;
                        if (!cl_bad && val_idx == 4'd5)
                            saw_cl = 1'b1;
                        p_state = PS_VALUE_LF;
                    end else if (val_idx >= 4'd10) begin
                        ka_bad = 1'b1;
                        cl_bad = 1'b1;
                    end else begin
                        if (b != KA_TEXT[8*(9 - val_idx) +: 8])
                            ka_bad = 1'b1;
                        if (val_idx >= 4'd5)
                            cl_bad = 1'b1;
                        else if (b != CL_TEXT[8*(4 - val_idx) +: 8])
                            cl_bad = 1'b1;
                        val_idx = val_idx + 4'd1;
                    end
                end
                PS_FINAL_LF: begin
                    if (b != LF) begin
                        reject_request();
                    end else begin
                        v11 = ver11;
                        ka  = saw_cl ? 1'b0 : (saw_ka || ver11);
                        restart_parse();
                        post_event(EV_COMPLETE, 8'h00, v11, ka);
                    end
                end
                default: reject_request();
            endcase
        end
    endtask

    // --- stimulus building ---

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            request_text.push_back(s[i]);
    endtask

    task automatic push_crlf();
        request_text.push_back(CR);
        request_text.push_back(LF);
    endtask

    task automatic commit_text();
        while (request_text.size() != 0)
            byte_feed.push_back(request_text.pop_front());
    endtask

    task automatic build_header();
        logic [7:0] c;
        string      key;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                key = "connection";
                for (int i = 0; i < key.len(); i++) begin
                    c = key[i];
                    if ($urandom_range(0, 1) == 1)
                        c = c - 8'd32;
                    request_text.push_back(c);
                end
            end
            3: begin
                repeat ($urandom_range(1, 6)) begin
                    c = $urandom_range(8'h21, 8'hFF);
                    if (c == COLON)
                        c = "_";
                    request_text.push_back(c);
                end
            end
            4: ;                          // empty key, colon opens the line
            5: push_text("Connectionx");
            6: push_text("connect");
            default: push_text("Host");
        endcase
        request_text.push_back(COLON);
        request_text.push_back(SPACE);
        case ($urandom_range(0, 7))
            0, 1: push_text("keep-alive");
            2, 3: push_text("close");
            4: ;
            5: push_text("keep-alives");
            6: push_text("clos");
            default: begin
                repeat ($urandom_range(1, 12)) begin
                    c = $urandom_range(0, 255);
                    if (c == CR)
                        c = "k";
                    request_text.push_back(c);
                end
            end
        endcase
        push_crlf();
    endtask

    task automatic build_request();
        logic [7:0] c;
        int         idx;
        push_text("GET ");
        repeat ($urandom_range(0, 8)) begin
            c = $urandom_range(0, 255);
            if (c == SPACE)
                c = "/";
            request_text.push_back(c);
        end
        push_text(" HTTP/1.");
        request_text.push_back($urandom_range(0, 1) ? "1" : "0");
        push_crlf();
        repeat ($urandom_range(0, 3))
            build_header();
        push_crlf();
        // break a share of the requests
        idx = $urandom_range(0, request_text.size() - 1);
        case ($urandom_range(0, 9))
            0: request_text[idx] = $urandom_range(0, 255);
            1: begin
                while (request_text.size() > idx)
                    void'(request_text.pop_back());
            end
            2: begin
                repeat ($urandom_range(1, 4))
                    request_text.push_back($urandom_range(0, 255));
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: request_text[idx] = CR;
                    1: request_text[idx] = LF;
                    2: request_text[idx] = COLON;
                    3: request_text[idx] = SPACE;
                    default: request_text[idx] = "1";
                endcase
            end
            default: ;
        endcase
        commit_text();
    endtask

    function automatic logic idling_on();
        return byte_feed.size() > CALM_TAIL;
    endfunction

    // --- drivers ---

    always @(negedge i_clk) begin : byte_driver
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap != 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (idling_on() && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 10);
                i_in_valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
                i_stream_byte <= byte_feed.pop_front();
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Hold off once for a long stretch so the parser backs up and drops ready
    always @(negedge i_clk) begin : event_drain
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_used && bytes_taken >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap = out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // --- monitor ---

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : event_monitor
        t_parse_event want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            in_taken = 1'b0;
            if (i_rst_n) begin
                if (i_in_valid && o_in_ready) begin
                    in_taken = 1'b1;
                    bytes_taken++;
                    parse_byte(i_stream_byte);
                end
                if (o_out_valid && i_out_ready) begin
                    if (due_events.size() == 0) begin
                        $error("event_kind: expected no event, got %0d", o_event_kind);
                        errors++;
                    end else begin
                        want = due_events.pop_front();
                        check_field("event_kind", want.kind, o_event_kind);
                        check_field("url_byte", want.url, o_url_byte);
                        check_field("version_is_11", want.v11, o_version_is_11);
                        check_field("keep_alive", want.ka, o_keep_alive);
                    end
                end
            end
        end
    end

    initial begin
        restart_parse();

        // Bad first bytes, CR and LF inside a url, bad minor version, empty url
        request_text.push_back(8'hFF);
        request_text.push_back(8'h00);
        push_text("GET ");
        push_crlf();
        push_text(" HTTP/1.2");
        push_text("GET  X");
        commit_text();

        while (byte_feed.size() < FEED_TARGET)
            build_request();
        feed_total = byte_feed.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < feed_total)
            @(negedge i_clk);
        while (due_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hrp_pkg.sv
hdl/hrp_front.sv
hdl/hrp_queue.sv
hdl/hrp_back.sv
hdl/http_request_header_parser.sv
test/tb_top.sv
